>>> rtl/cidr_block_aggregator_core_defines.svh
// Assertion macros used by the checker file.
`ifndef CIDR_BLOCK_AGGREGATOR_CORE_DEFINES_SVH
`define CIDR_BLOCK_AGGREGATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CBA_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cba assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define CBA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cba assertion failed");

`endif

>>> rtl/cba_pkg.sv
package cba_pkg;

   localparam int DEFAULT_STORE_DEPTH = 1024;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;

   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_FULL          = 2'd1;
   localparam logic [1:0] ST_NOT_ASCENDING = 2'd2;
   localparam logic [1:0] ST_NO_MORE       = 2'd3;

   localparam logic [5:0] PREFIX_WIDEST = 6'd24;
   localparam logic [5:0] PREFIX_HOST   = 6'd32;

   // probe shift: block size is 1 << shift, shift 1 (/31) up to 8 (/24)
   localparam logic [3:0] SHIFT_FIRST = 4'd1;
   localparam logic [3:0] SHIFT_LAST  = 4'd8;

endpackage

>>> rtl/cidr_block_aggregator_core.sv
// CIDR block aggregator.
// Input channel req_*: one item per command. req_tuser carries the command
// (clear, add, fetch), req_tdata the IPv4 address used by add.
// Result channel rsp_*: exactly one item per input item, in order.
// rsp_tuser carries the status, rsp_tdata the block base and prefix length.
// Clear and add finish in the accept cycle; the result is visible the next
// cycle. A fetch reads the base entry, then probes block sizes /31 down to
// /24 on the single store read port; an aligned in-range probe reads the
// store and compares, and a skipped probe moves on to the next size.
// An exhausted fetch answers at once like clear and add.
// The block takes one item at a time; req_tready is high only in idle with
// the result register empty or being drained in the same cycle.
// A stalled result holds in the output register and blocks new items.
// Reset clears the count, the walk index, the last address and the output
// valid; the store contents are not cleared and need no clearing pass.
module cidr_block_aggregator_core
   import cba_pkg::*;
#(
   parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] base_addr, [37:32] prefix_len, [39:38] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_BASE  = 4'b0010,
      S_PROBE = 4'b0100,
      S_CMP   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  next_ff, next_in;
   logic [31:0]       last_ff, last_in;
   logic [31:0]       base_ff, base_in;
   logic [3:0]        shift_ff, shift_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [31:0]       rsp_base_ff, rsp_base_in;
   logic [5:0]        rsp_prefix_ff, rsp_prefix_in;

   logic [31:0]       store [STORE_DEPTH];
   logic [31:0]       rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;

   logic              accept;
   logic              rsp_load;
   logic [7:0]        mask;
   logic [8:0]        size;
   logic [31:0]       opa;
   logic [31:0]       sum;
   logic              aligned;
   logic              in_range;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_prefix_ff, rsp_base_ff};

   // shared adder: index of the probe's last entry, or expected last address
   assign mask     = 8'((9'd1 << shift_ff) - 9'd1);
   assign size     = 9'd1 << shift_ff;
   assign opa      = (state_ff == S_CMP) ? base_ff : 32'(next_ff);
   assign sum      = opa + {24'd0, mask};
   assign aligned  = (base_ff[7:0] & mask) == 8'd0;
   assign in_range = sum < 32'(count_ff);

   assign rd_addr = (state_ff == S_PROBE) ? sum[IDX_W-1:0] : next_ff[IDX_W-1:0];
   assign wr_en   = accept && (req_tuser == CMD_ADD) && (count_ff < CNT_W'(STORE_DEPTH))
                    && !((count_ff != '0) && (req_tdata <= last_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[count_ff[IDX_W-1:0]] <= req_tdata;
      end
      rd_data_ff <= store[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      next_in       = next_ff;
      last_in       = last_ff;
      base_in       = base_ff;
      shift_in      = shift_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ST_OK;
      rsp_base_in   = 32'd0;
      rsp_prefix_in = PREFIX_HOST;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req_tuser)
                  CMD_CLEAR: begin
                     count_in = '0;
                     next_in  = '0;
                     last_in  = 32'd0;
                  end
                  CMD_ADD: begin
                     if (count_ff >= CNT_W'(STORE_DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else if ((count_ff != '0) && (req_tdata <= last_ff)) begin
                        rsp_status_in = ST_NOT_ASCENDING;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                        last_in  = req_tdata;
                     end
                  end
                  CMD_FETCH: begin
                     if (next_ff >= count_ff) begin
                        rsp_status_in = ST_NO_MORE;
                     end else begin
                        rsp_load = 1'b0;
                        state_in = S_BASE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BASE: begin
            base_in  = rd_data_ff;
            shift_in = SHIFT_FIRST;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (aligned && in_range) begin
               state_in = S_CMP;
            end else if (shift_ff == SHIFT_LAST) begin
               rsp_load    = 1'b1;
               rsp_base_in = base_ff;
               next_in     = next_ff + CNT_W'(1);
               state_in    = S_IDLE;
            end else begin
               shift_in = shift_ff + 4'd1;
            end
         end
         S_CMP: begin
            if (rd_data_ff == sum) begin
               rsp_load      = 1'b1;
               rsp_base_in   = base_ff;
               rsp_prefix_in = PREFIX_HOST - {2'b00, shift_ff};
               next_in       = next_ff + CNT_W'(size);
               state_in      = S_IDLE;
            end else if (shift_ff == SHIFT_LAST) begin
               rsp_load    = 1'b1;
               rsp_base_in = base_ff;
               next_in     = next_ff + CNT_W'(1);
               state_in    = S_IDLE;
            end else begin
               shift_in = shift_ff + 4'd1;
               state_in = S_PROBE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_ff      <= '0;
         last_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      shift_ff <= shift_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_base_ff   <= rsp_base_in;
         rsp_prefix_ff <= rsp_prefix_in;
      end
   end

endmodule

>>> rtl/cba_checker.sv
`include "cidr_block_aggregator_core_defines.svh"

module cba_checker
   import cba_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic [31:0] rsp_base;
   logic [5:0]  rsp_prefix;
   logic        rsp_stall;
   logic        rsp_refused;

   assign rsp_base    = rsp_tdata[31:0];
   assign rsp_prefix  = rsp_tdata[37:32];
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_refused = rsp_tvalid && (rsp_tuser != ST_OK);

   // stalled result holds
   `CBA_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable({rsp_tuser, rsp_tdata}))

   // failed results (status not OK) carry no block
   `CBA_ASSERT_IMP(a_no_block, rsp_refused, (rsp_base == 32'd0) && (rsp_prefix == PREFIX_HOST))

   // prefix stays within /24 .. /32
   `CBA_ASSERT_IMP(a_prefix, rsp_tvalid, rsp_prefix >= PREFIX_WIDEST && rsp_prefix <= PREFIX_HOST)

   // a /24 block base is aligned
   `CBA_ASSERT_IMP(a_align24, rsp_tvalid && (rsp_prefix == PREFIX_WIDEST), rsp_base[7:0] == 8'd0)

   // an accepted item either answers next cycle or keeps the input closed
   `CBA_ASSERT_NXT(a_one_item, req_tvalid && req_tready, rsp_tvalid || !req_tready)

endmodule

bind cidr_block_aggregator_core cba_checker u_cba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
